// File: hdl/sht_pkg.sv
// Package for the string key hash table: parameter defaults, operation and status
// codes, and the controller state type.
// It depends on nothing else and is compiled first.
package sht_pkg;

	localparam int MAX_SIZE_LOG2_DEF = 12;
	localparam int KEY_BYTES_DEF     = 8;

	localparam int LEN_W   = 4;
	localparam int VALUE_W = 32;
	localparam int CHARS_W = 64;

	localparam logic [3:0] SIZE_LOG2_RESET = 4'd12;

	localparam logic [1:0] OP_SEARCH = 2'd0;
	localparam logic [1:0] OP_INSERT = 2'd1;
	localparam logic [1:0] OP_CLEAR  = 2'd2;

	localparam logic [1:0] STAT_OK   = 2'd0;
	localparam logic [1:0] STAT_MISS = 2'd1;
	localparam logic [1:0] STAT_DUP  = 2'd2;
	localparam logic [1:0] STAT_FULL = 2'd3;

	localparam logic [VALUE_W-1:0] NO_VALUE = 32'hFFFF_FFFF;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_START,
		ST_PROBE,
		ST_DONE
	} state_t;

endpackage

// File: hdl/string_key_hash_table.sv
// Top level of the string key hash table: key normalisation, probe controller and
// the slot memories.
// It depends on sht_pkg for codes, the state type and parameter defaults.
//
// Usage. The input channel (in_valid, in_stall) carries one operation per transfer:
// search, insert or clear, with a key of up to KEY_BYTES characters and a value.
// Every operation gives exactly one result transfer on the output channel
// (out_valid, out_stall) with a status, the value found, the slot and the item count.
// The write channel (cfg_valid, cfg_ready) sets size_log2; it is always ready and
// must only be used while the block is idle.
// Probing. A search or insert probes 1 to 2^size_log2 slots, with a size_log2 of 0
// read as 1 and one above MAX_SIZE_LOG2 read as MAX_SIZE_LOG2; the slot memory is
// read once per cycle through its single port, which sets the probe rate. A clear
// sweeps all 2^MAX_SIZE_LOG2 slots, one per cycle, whatever size_log2 is. A new
// operation is taken once the previous result has been placed in the output register.
// Reset. After arst_n is released the block sweeps all 2^MAX_SIZE_LOG2 slots empty,
// one per cycle, holding in_stall high; configuration writes are taken meanwhile.
// Stall. A stalled result stays in the output register; the next result waits in
// the controller, which then holds in_stall high until the register frees.
module string_key_hash_table #(
	parameter int MAX_SIZE_LOG2 = sht_pkg::MAX_SIZE_LOG2_DEF,
	parameter int KEY_BYTES     = sht_pkg::KEY_BYTES_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [3:0]                        cfg_data,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [1:0]                        opcode,
	input  logic [sht_pkg::CHARS_W-1:0]       key_chars,
	input  logic [sht_pkg::LEN_W-1:0]         key_length,
	input  logic signed [sht_pkg::VALUE_W-1:0] new_value,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [1:0]                        status,
	output logic signed [sht_pkg::VALUE_W-1:0] found_value,
	output logic [MAX_SIZE_LOG2-1:0]          slot_index,
	output logic [MAX_SIZE_LOG2:0]            item_count
);

	localparam int AW    = MAX_SIZE_LOG2;
	localparam int DEPTH = 1 << AW;
	localparam int KW    = 7 * KEY_BYTES;
	localparam int LW    = sht_pkg::LEN_W;
	localparam int VW    = sht_pkg::VALUE_W;
	localparam int HW    = KEY_BYTES + 6;
	localparam int HXW   = (HW > AW) ? HW : AW;

	logic            mem_occ [DEPTH];
	logic [LW-1:0]   mem_len [DEPTH];
	logic [KW-1:0]   mem_key [DEPTH];
	logic [VW-1:0]   mem_val [DEPTH];

	logic            rd_occ_q;
	logic [LW-1:0]   rd_len_q;
	logic [KW-1:0]   rd_key_q;
	logic [VW-1:0]   rd_val_q;

	logic            mem_we;
	logic [AW-1:0]   mem_addr;
	logic            mem_wocc;

	sht_pkg::state_t state_q, state_d;

	logic [3:0]      size_q;
	logic [AW:0]     count_q;
	logic [1:0]      op_q;
	logic [KW-1:0]   key_q;
	logic [LW-1:0]   len_q;
	logic [AW-1:0]   hash_q;
	logic [VW-1:0]   val_q;
	logic [AW-1:0]   p_q;
	logic [AW-1:0]   sweep_q;
	logic            clr_res_q;
	logic [1:0]      res_status_q;
	logic [VW-1:0]   res_found_q;
	logic [AW-1:0]   res_slot_q;

	logic            out_valid_q;
	logic [1:0]      status_q;
	logic [VW-1:0]   found_q;
	logic [AW-1:0]   slot_q;
	logic [AW:0]     item_count_q;

	logic [KW-1:0]   norm_key;
	logic [LW-1:0]   norm_len;
	logic [HXW-1:0]  norm_hash;

	logic [3:0]      used_log2;
	logic [AW:0]     size_full;
	logic [AW-1:0]   mask;
	logic [AW-1:0]   addr_cur;
	logic [AW-1:0]   addr_next;
	logic            hit_empty;
	logic            hit_match;
	logic            last_probe;
	logic            in_xfer;
	logic            out_free;
	logic            sweep_end;

	assign cfg_ready = 1'b1;

	// The key ends at its length or at the first zero character, whichever comes first.
	always_comb begin
		logic [6:0]    c;
		logic [LW-1:0] eff_len;
		logic          stop;
		norm_key  = '0;
		norm_len  = '0;
		norm_hash = '0;
		stop      = 1'b0;
		eff_len   = (key_length > LW'(KEY_BYTES)) ? LW'(KEY_BYTES) : key_length;
		for (int i = 0; i < KEY_BYTES; i++) begin
			c = key_chars[8*i +: 7];
			if (!stop && (LW'(i) < eff_len)) begin
				if (c == 7'd0) begin
					stop = 1'b1;
				end else begin
					if (c >= 7'h41 && c <= 7'h5A) begin
						c = c + 7'h20;
					end
					norm_key[7*i +: 7] = c;
					norm_hash = norm_hash ^ (HXW'(c) << i);
					norm_len  = LW'(i + 1);
				end
			end
		end
	end

	always_comb begin
		if (size_q == 4'd0) begin
			used_log2 = 4'd1;
		end else if (size_q > 4'(MAX_SIZE_LOG2)) begin
			used_log2 = 4'(MAX_SIZE_LOG2);
		end else begin
			used_log2 = size_q;
		end
	end

	assign size_full  = (AW+1)'(1) << used_log2;
	assign mask       = size_full[AW-1:0] - AW'(1);
	assign addr_cur   = (hash_q + p_q) & mask;
	assign addr_next  = (hash_q + p_q + AW'(1)) & mask;
	assign hit_empty  = !rd_occ_q;
	assign hit_match  = rd_occ_q && (rd_key_q == key_q) && (rd_len_q == len_q);
	assign last_probe = (p_q == mask);
	assign sweep_end  = (sweep_q == {AW{1'b1}});
	assign out_free   = !out_valid_q || !out_stall;
	assign in_xfer    = in_valid && !in_stall;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			sht_pkg::ST_CLEAR: begin
				if (sweep_end) begin
					state_d = clr_res_q ? sht_pkg::ST_DONE : sht_pkg::ST_IDLE;
				end
			end
			sht_pkg::ST_IDLE: begin
				if (in_valid) begin
					unique case (opcode) inside
						sht_pkg::OP_SEARCH, sht_pkg::OP_INSERT: state_d = sht_pkg::ST_START;
						sht_pkg::OP_CLEAR:                      state_d = sht_pkg::ST_CLEAR;
						default:                                state_d = sht_pkg::ST_DONE;
					endcase
				end
			end
			sht_pkg::ST_START: state_d = sht_pkg::ST_PROBE;
			sht_pkg::ST_PROBE: begin
				if (hit_empty || hit_match || last_probe) begin
					state_d = sht_pkg::ST_DONE;
				end
			end
			sht_pkg::ST_DONE: begin
				if (out_free) begin
					state_d = sht_pkg::ST_IDLE;
				end
			end
			default: state_d = sht_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		in_stall = 1'b1;
		mem_we   = 1'b0;
		mem_wocc = 1'b0;
		mem_addr = addr_next;
		unique case (state_q)
			sht_pkg::ST_CLEAR: begin
				mem_we   = 1'b1;
				mem_addr = sweep_q;
			end
			sht_pkg::ST_IDLE:  in_stall = 1'b0;
			sht_pkg::ST_START: mem_addr = addr_cur;
			sht_pkg::ST_PROBE: begin
				if (hit_empty && op_q == sht_pkg::OP_INSERT) begin
					mem_we   = 1'b1;
					mem_wocc = 1'b1;
					mem_addr = addr_cur;
				end
			end
			sht_pkg::ST_DONE: ;
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_occ[mem_addr] <= mem_wocc;
			mem_len[mem_addr] <= mem_wocc ? len_q : '0;
			mem_key[mem_addr] <= mem_wocc ? key_q : '0;
			mem_val[mem_addr] <= mem_wocc ? val_q : '0;
		end
		rd_occ_q <= mem_occ[mem_addr];
		rd_len_q <= mem_len[mem_addr];
		rd_key_q <= mem_key[mem_addr];
		rd_val_q <= mem_val[mem_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= sht_pkg::ST_CLEAR;
			size_q      <= sht_pkg::SIZE_LOG2_RESET;
			count_q     <= '0;
			sweep_q     <= '0;
			clr_res_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid) begin
				size_q <= cfg_data;
			end
			if (state_q == sht_pkg::ST_CLEAR) begin
				sweep_q <= sweep_q + AW'(1);
			end
			if (in_xfer && opcode == sht_pkg::OP_CLEAR) begin
				count_q   <= '0;
				sweep_q   <= '0;
				clr_res_q <= 1'b1;
			end
			if (state_q == sht_pkg::ST_PROBE && hit_empty && op_q == sht_pkg::OP_INSERT) begin
				count_q <= count_q + (AW+1)'(1);
			end
			if (state_q == sht_pkg::ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			op_q         <= opcode;
			key_q        <= norm_key;
			len_q        <= norm_len;
			hash_q       <= norm_hash[AW-1:0];
			val_q        <= new_value;
			p_q          <= '0;
			res_status_q <= sht_pkg::STAT_OK;
			res_found_q  <= sht_pkg::NO_VALUE;
			res_slot_q   <= '0;
		end
		if (state_q == sht_pkg::ST_PROBE) begin
			if (hit_empty) begin
				if (op_q == sht_pkg::OP_INSERT) begin
					res_slot_q <= addr_cur;
				end else begin
					res_status_q <= sht_pkg::STAT_MISS;
				end
			end else if (hit_match) begin
				res_slot_q <= addr_cur;
				if (op_q == sht_pkg::OP_INSERT) begin
					res_status_q <= sht_pkg::STAT_DUP;
				end else begin
					res_found_q <= rd_val_q;
				end
			end else if (last_probe) begin
				res_status_q <= (op_q == sht_pkg::OP_INSERT) ? sht_pkg::STAT_FULL
					: sht_pkg::STAT_MISS;
			end else begin
				p_q <= p_q + AW'(1);
			end
		end
		if (state_q == sht_pkg::ST_DONE && out_free) begin
			status_q     <= res_status_q;
			found_q      <= res_found_q;
			slot_q       <= res_slot_q;
			item_count_q <= count_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign found_value = found_q;
	assign slot_index  = slot_q;
	assign item_count  = item_count_q;

endmodule
